// File: src/srsp_pkg.sv
package srsp_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int REQ_W     = 3;
    localparam int FIELD_W   = 10;
    localparam int LIVE_W    = 11;
    localparam int STATUS_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD     = 3'd0,
        REQ_RM_POS  = 3'd1,
        REQ_RM_SLOT = 3'd2,
        REQ_LOOKUP  = 3'd3,
        REQ_EXIST   = 3'd4,
        REQ_RECOVER = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_wr;
        logic accept;
        logic eval;
        logic wr1;
        logic wr2;
        logic fin_load;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic init_last;
        logic swap;
        logic out_free;
    } stat_t;

endpackage

// File: src/srsp_ctrl.sv
module srsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  srsp_pkg::stat_t  st,
    output srsp_pkg::cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_EVAL = 6'b000100,
        S_WR1  = 6'b001000,
        S_WR2  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (st.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = st.swap ? S_WR1 : S_FIN;
            end
            S_WR1:
            begin
                cmd.wr1    = 1'b1;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                cmd.wr2    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.fin_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

// File: src/srsp_datapath.sv
module srsp_datapath #(
    parameter int SLOTS = srsp_pkg::SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  srsp_pkg::cmd_t                 cmd,
    output srsp_pkg::stat_t                st,
    input  logic [srsp_pkg::REQ_W-1:0]     req_type,
    input  logic [srsp_pkg::FIELD_W-1:0]   position,
    input  logic [srsp_pkg::FIELD_W-1:0]   slot,
    input  logic [srsp_pkg::FIELD_W-1:0]   step,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [srsp_pkg::STATUS_W-1:0]  status,
    output logic [srsp_pkg::FIELD_W-1:0]   slot_out,
    output logic [srsp_pkg::FIELD_W-1:0]   position_out,
    output logic [srsp_pkg::LIVE_W-1:0]    live_count,
    output logic                           exists
);

    localparam int IDXW = $clog2(SLOTS);
    // Wide enough for any input field, any index and their sum.
    localparam int XW = ((IDXW > srsp_pkg::FIELD_W) ? IDXW : srsp_pkg::FIELD_W) + 1;
    localparam logic [XW-1:0]   SLOTS_X  = XW'(SLOTS);
    localparam logic [XW-1:0]   LIMIT_X  = XW'(SLOTS - 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

    // Position-to-slot map (two read ports) and slot-to-position map.
    logic [IDXW-1:0] sap_mem [SLOTS];
    logic [IDXW-1:0] pos_mem [SLOTS];

    logic [IDXW-1:0] init_cnt_reg;
    logic [IDXW-1:0] init_cnt_next;
    logic [IDXW-1:0] count_reg;
    logic [IDXW-1:0] count_next;
    logic            result_valid_reg;
    logic            result_valid_next;

    logic [srsp_pkg::REQ_W-1:0]   req_reg;
    logic [srsp_pkg::FIELD_W-1:0] pos_in_reg;
    logic [srsp_pkg::FIELD_W-1:0] slt_in_reg;
    logic [srsp_pkg::FIELD_W-1:0] stp_in_reg;
    logic [IDXW-1:0]              sap_a_reg;
    logic [IDXW-1:0]              sap_b_reg;
    logic [IDXW-1:0]              pos_rd_reg;

    logic [IDXW-1:0] p_reg;
    logic [IDXW-1:0] tslot_reg;
    logic [IDXW-1:0] lslot_reg;
    logic [IDXW-1:0] last_reg;

    srsp_pkg::status_t res_status_reg;
    logic [IDXW-1:0]   res_slot_reg;
    logic [IDXW-1:0]   res_pos_reg;
    logic              res_ex_reg;

    srsp_pkg::status_t status_reg;
    logic [IDXW-1:0]   slot_out_reg;
    logic [IDXW-1:0]   pos_out_reg;
    logic [IDXW-1:0]   live_reg;
    logic              exists_reg;

    logic [IDXW-1:0] rd_addr_a;
    logic            wr_en;
    logic [IDXW-1:0] sap_wa;
    logic [IDXW-1:0] sap_wd;
    logic [IDXW-1:0] pos_wa;
    logic [IDXW-1:0] pos_wd;

    srsp_pkg::status_t ev_status;
    logic [IDXW-1:0]   ev_slot;
    logic [IDXW-1:0]   ev_pos;
    logic              ev_ex;
    logic              ev_swap;
    logic [IDXW-1:0]   ev_count;
    logic [IDXW-1:0]   ev_p;
    logic [IDXW-1:0]   ev_tslot;
    logic [XW-1:0]     rec_sum;
    logic              pool_empty;

    // Reads are issued straight from the ports on the accepting edge.
    assign rd_addr_a = (srsp_pkg::req_t'(req_type) == srsp_pkg::REQ_ADD) ?
                       count_reg : IDXW'(position);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sap_a_reg  <= sap_mem[rd_addr_a];
            sap_b_reg  <= sap_mem[count_reg - IDXW'(1)];
            pos_rd_reg <= pos_mem[IDXW'(slot)];
        end
        if (wr_en)
        begin
            sap_mem[sap_wa] <= sap_wd;
            pos_mem[pos_wa] <= pos_wd;
        end
    end

    // After reset both maps are swept to the identity, one entry a cycle.
    always_comb
    begin
        wr_en  = cmd.init_wr | cmd.wr1 | cmd.wr2;
        sap_wa = init_cnt_reg;
        sap_wd = init_cnt_reg;
        pos_wa = init_cnt_reg;
        pos_wd = init_cnt_reg;
        if (cmd.wr1)
        begin
            sap_wa = p_reg;
            sap_wd = lslot_reg;
            pos_wa = lslot_reg;
            pos_wd = p_reg;
        end
        else if (cmd.wr2)
        begin
            sap_wa = last_reg;
            sap_wd = tslot_reg;
            pos_wa = tslot_reg;
            pos_wd = last_reg;
        end
    end

    always_comb
    begin
        pool_empty = (count_reg == '0);
        rec_sum    = XW'(count_reg) + XW'(stp_in_reg);
        ev_status  = srsp_pkg::ST_OK;
        ev_slot    = '0;
        ev_pos     = '0;
        ev_ex      = 1'b0;
        ev_swap    = 1'b0;
        ev_count   = count_reg;
        ev_p       = IDXW'(pos_in_reg);
        ev_tslot   = sap_a_reg;
        unique case (srsp_pkg::req_t'(req_reg))
            srsp_pkg::REQ_ADD:
            begin
                if (XW'(count_reg) >= LIMIT_X)
                begin
                    ev_status = srsp_pkg::ST_FULL;
                end
                else
                begin
                    ev_slot  = sap_a_reg;
                    ev_pos   = count_reg;
                    ev_count = count_reg + IDXW'(1);
                end
            end
            srsp_pkg::REQ_RM_POS:
            begin
                if (pool_empty)
                begin
                    ev_status = srsp_pkg::ST_EMPTY;
                end
                else if (XW'(pos_in_reg) >= XW'(count_reg))
                begin
                    ev_status = srsp_pkg::ST_BAD;
                end
                else
                begin
                    ev_slot  = sap_a_reg;
                    ev_pos   = IDXW'(pos_in_reg);
                    ev_swap  = 1'b1;
                    ev_count = count_reg - IDXW'(1);
                end
            end
            srsp_pkg::REQ_RM_SLOT:
            begin
                // The maps are inverse permutations, so the slot itself is
                // what the position map points back to.
                ev_p     = pos_rd_reg;
                ev_tslot = IDXW'(slt_in_reg);
                if (pool_empty)
                begin
                    ev_status = srsp_pkg::ST_EMPTY;
                end
                else if ((XW'(slt_in_reg) >= SLOTS_X) ||
                         (XW'(pos_rd_reg) >= XW'(count_reg)))
                begin
                    ev_status = srsp_pkg::ST_BAD;
                end
                else
                begin
                    ev_slot  = IDXW'(slt_in_reg);
                    ev_pos   = pos_rd_reg;
                    ev_swap  = 1'b1;
                    ev_count = count_reg - IDXW'(1);
                end
            end
            srsp_pkg::REQ_LOOKUP:
            begin
                if (XW'(pos_in_reg) >= SLOTS_X)
                begin
                    ev_status = srsp_pkg::ST_BAD;
                end
                else
                begin
                    ev_slot = sap_a_reg;
                    ev_pos  = IDXW'(pos_in_reg);
                end
            end
            srsp_pkg::REQ_EXIST:
            begin
                if (XW'(slt_in_reg) >= SLOTS_X)
                begin
                    ev_status = srsp_pkg::ST_BAD;
                end
                else
                begin
                    ev_slot = IDXW'(slt_in_reg);
                    ev_pos  = pos_rd_reg;
                    ev_ex   = (pos_rd_reg < count_reg);
                end
            end
            srsp_pkg::REQ_RECOVER:
            begin
                if (rec_sum > LIMIT_X)
                begin
                    ev_status = srsp_pkg::ST_FULL;
                end
                else
                begin
                    ev_count = IDXW'(rec_sum);
                end
            end
            default:
            begin
                ev_status = srsp_pkg::ST_BAD;
            end
        endcase
    end

    always_comb
    begin
        init_cnt_next     = init_cnt_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        if (cmd.init_wr)
        begin
            init_cnt_next = init_cnt_reg + IDXW'(1);
        end
        if (cmd.eval)
        begin
            count_next = ev_count;
        end
        if (cmd.fin_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg     <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            init_cnt_reg     <= init_cnt_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg    <= req_type;
            pos_in_reg <= position;
            slt_in_reg <= slot;
            stp_in_reg <= step;
        end
        if (cmd.eval)
        begin
            res_status_reg <= ev_status;
            res_slot_reg   <= ev_slot;
            res_pos_reg    <= ev_pos;
            res_ex_reg     <= ev_ex;
            p_reg          <= ev_p;
            tslot_reg      <= ev_tslot;
            lslot_reg      <= sap_b_reg;
            last_reg       <= count_reg - IDXW'(1);
        end
        if (cmd.fin_load)
        begin
            status_reg   <= res_status_reg;
            slot_out_reg <= res_slot_reg;
            pos_out_reg  <= res_pos_reg;
            live_reg     <= count_reg;
            exists_reg   <= res_ex_reg;
        end
    end

    assign st.init_last = (init_cnt_reg == LAST_IDX);
    assign st.swap      = ev_swap;
    assign st.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign slot_out     = srsp_pkg::FIELD_W'(slot_out_reg);
    assign position_out = srsp_pkg::FIELD_W'(pos_out_reg);
    assign live_count   = srsp_pkg::LIVE_W'(live_reg);
    assign exists       = exists_reg;

endmodule

// File: src/swap_remove_slot_pool_core.sv
// Steps: an accepted item is evaluated, then finished into the output registers, for add,
// lookup, exist, recover and failed requests; a successful remove writes the two halves of
// its swap in turn between those steps, on the single write port of each map.
// A new item is taken only once the last one has finished; a stalled result holds the
// finishing step. Reset is asynchronous, active low; afterwards both maps are swept to the
// identity, one entry at a time over all SLOTS entries, taking no item.
module swap_remove_slot_pool_core #(
    parameter int SLOTS = srsp_pkg::SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [srsp_pkg::REQ_W-1:0]     req_type,
    input  logic [srsp_pkg::FIELD_W-1:0]   position,
    input  logic [srsp_pkg::FIELD_W-1:0]   slot,
    input  logic [srsp_pkg::FIELD_W-1:0]   step,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [srsp_pkg::STATUS_W-1:0]  status,
    output logic [srsp_pkg::FIELD_W-1:0]   slot_out,
    output logic [srsp_pkg::FIELD_W-1:0]   position_out,
    output logic [srsp_pkg::LIVE_W-1:0]    live_count,
    output logic                           exists
);

    srsp_pkg::cmd_t  cmd;
    srsp_pkg::stat_t st;

    srsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    srsp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .req_type     (req_type),
        .position     (position),
        .slot         (slot),
        .step         (step),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .slot_out     (slot_out),
        .position_out (position_out),
        .live_count   (live_count),
        .exists       (exists)
    );

    // A new result appears only when the controller finishes an item.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.fin_load))
        else $error("result appeared without a finishing step");

    // Only one item is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> req_stall)
        else $error("input taken again right after an accept");

    // The two halves of a swap are written on consecutive cycles.
    a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr1 |=> cmd.wr2)
        else $error("second swap write missing");

    // No item is taken while the maps are still being initialized.
    a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_wr |-> (req_stall && !cmd.accept))
        else $error("item accepted during map initialization");

endmodule
